@@ rtl/core/tpa_pkg.sv @@
// Shared word types for the triangle perimeter and area unit.
package tpa_pkg;

    localparam int IN_FIELD_W = 16;
    localparam int PERIM_W    = 27;
    localparam int AREA_W     = 40;

    typedef struct packed {
        logic signed [IN_FIELD_W-1:0] first_x;
        logic signed [IN_FIELD_W-1:0] first_y;
        logic signed [IN_FIELD_W-1:0] second_x;
        logic signed [IN_FIELD_W-1:0] second_y;
        logic signed [IN_FIELD_W-1:0] third_x;
        logic signed [IN_FIELD_W-1:0] third_y;
    } t_in_word;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  area;
    } t_out_word;

endpackage

@@ rtl/core/tpa_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a carried sideband.
module tpa_isqrt #(
    parameter int IN_W   = 49,
    parameter int SIDE_W = 1,
    localparam int RT_W  = (IN_W + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RT_W-1:0]   o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int PAD_W = 2 * RT_W;
    localparam int REM_W = RT_W + 2;

    logic [REM_W-1:0]  r_rem  [RT_W];
    logic [RT_W-1:0]   r_root [RT_W];
    logic [PAD_W-1:0]  r_rad  [RT_W];
    logic [SIDE_W-1:0] r_side [RT_W];
    logic [RT_W-1:0]   r_valid;

    for (genvar g = 0; g < RT_W; g++) begin : g_stage
        logic [REM_W-1:0]  p_rem;
        logic [RT_W-1:0]   p_root;
        logic [PAD_W-1:0]  p_rad;
        logic [SIDE_W-1:0] p_side;
        logic              p_valid;
        logic [REM_W:0]    cur;
        logic [REM_W:0]    trial;
        logic [REM_W:0]    diff;
        logic              ge;
        logic [REM_W-1:0]  n_rem;
        logic [RT_W-1:0]   n_root;

        if (g == 0) begin : g_first
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_rad   = PAD_W'(i_rad);
            assign p_side  = i_side;
            assign p_valid = i_valid;
        end else begin : g_next
            assign p_rem   = r_rem[g-1];
            assign p_root  = r_root[g-1];
            assign p_rad   = r_rad[g-1];
            assign p_side  = r_side[g-1];
            assign p_valid = r_valid[g-1];
        end

        assign cur    = {p_rem[REM_W-2:0], p_rad[PAD_W-1 -: 2]};
        assign trial  = (REM_W+1)'({p_root, 2'b01});
        assign diff   = cur - trial;
        assign ge     = cur >= trial;
        assign n_rem  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        assign n_root = {p_root[RT_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= p_rad << 2;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[RT_W-1];
    assign o_root  = r_root[RT_W-1];
    assign o_side  = r_side[RT_W-1];

endmodule

@@ rtl/core/tpa_fifo.sv @@
// Small register queue with registered occupancy count.
module tpa_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_room,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_room  = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && o_room;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_room))
        else $error("push into full queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule

@@ rtl/core/tpa_front.sv @@
// Front end: vertex differences, squared distances and pipelined side roots.
module tpa_front
    import tpa_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    localparam int SIDE_W    = COORD_BITS + FRAC_BITS + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_in_word            i_word,
    output logic                o_ready,
    input  logic                i_q_room,
    output logic                o_push,
    output logic [3*SIDE_W-1:0] o_sides
);

    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C;
    localparam int RAD_W = 2 * C + 1 + 2 * FRAC_BITS;

    logic         en;
    logic         last_valid;
    logic [C-1:0] cx [3];
    logic [C-1:0] cy [3];
    logic [C-1:0] n_mag [6];
    logic [C-1:0] r_mag [6];
    logic [SQ_W-1:0] r_sq [6];
    logic         r_v1;
    logic         r_v2;
    logic [RAD_W-1:0] rad [3];
    logic [SIDE_W-1:0] side [3];

    assign cx[0] = C'($unsigned(i_word.first_x));
    assign cy[0] = C'($unsigned(i_word.first_y));
    assign cx[1] = C'($unsigned(i_word.second_x));
    assign cy[1] = C'($unsigned(i_word.second_y));
    assign cx[2] = C'($unsigned(i_word.third_x));
    assign cy[2] = C'($unsigned(i_word.third_y));

    function automatic logic [C-1:0] f_mag(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C:0] d;
        logic [C:0] m;
        d = {a[C-1], a} - {b[C-1], b};
        m = d[C] ? (~d + 1'b1) : d;
        return m[C-1:0];
    endfunction

    // side a: first-second, side b: third-second, side c: first-third
    assign n_mag[0] = f_mag(cx[0], cx[1]);
    assign n_mag[1] = f_mag(cy[0], cy[1]);
    assign n_mag[2] = f_mag(cx[2], cx[1]);
    assign n_mag[3] = f_mag(cy[2], cy[1]);
    assign n_mag[4] = f_mag(cx[0], cx[2]);
    assign n_mag[5] = f_mag(cy[0], cy[2]);

    assign en      = !last_valid || i_q_room;
    assign o_ready = en;
    assign o_push  = last_valid && i_q_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                r_mag[k] <= n_mag[k];
                r_sq[k]  <= r_mag[k] * r_mag[k];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic lane_valid;
        logic lane_side;

        assign rad[l] = (RAD_W'(r_sq[2*l]) + RAD_W'(r_sq[2*l+1])) << (2 * FRAC_BITS);

        tpa_isqrt #(
            .IN_W   (RAD_W),
            .SIDE_W (1)
        ) u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_v2),
            .i_rad   (rad[l]),
            .i_side  (1'b0),
            .o_valid (lane_valid),
            .o_root  (side[l]),
            .o_side  (lane_side)
        );

        if (l == 0) begin : g_lead
            assign last_valid = lane_valid;
        end
    end

    assign o_sides = {side[0], side[1], side[2]};

endmodule

@@ rtl/core/tpa_back.sv @@
// Back end: perimeter, Heron factors, split products and the area root.
module tpa_back
    import tpa_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    localparam int SIDE_W    = COORD_BITS + FRAC_BITS + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  logic [3*SIDE_W-1:0] i_q_sides,
    output logic                o_q_pop,
    input  logic                i_out_room,
    output logic                o_push,
    output t_out_word           o_word
);

    localparam int PB    = SIDE_W + 2;
    localparam int H1    = (PB + 1) / 2;
    localparam int M_W   = 2 * PB;
    localparam int H2    = PB;
    localparam int PR_W  = 4 * PB;
    localparam int SH    = 2 * FRAC_BITS + 4;
    localparam int AR_W  = PR_W - SH;
    localparam int RT_W  = (AR_W + 1) / 2;

    logic en;
    logic area_valid;
    logic [SIDE_W-1:0] sa, sb, sc;
    logic [5:0] r_v;

    logic [PB-1:0] r1_p, r1_a, r1_b, r1_c;
    logic [PB-1:0] r2_p, r2_fa, r2_fb, r2_fc;
    logic [PB-1:0] r3_p, r4_p, r5_p, r6_p;
    logic [2*H1-1:0] r3_pp [8];
    logic [M_W-1:0]  r4_m1, r4_m2;
    logic [M_W-1:0]  r5_pp [4];
    logic [PR_W-1:0] r6_prod;
    logic [RT_W-1:0] root;
    logic [PB-1:0]   perim;

    function automatic logic [PB-1:0] f_factor(input logic [PB-1:0] p, input logic [PB-1:0] s);
        logic [PB:0] twice;
        twice = {s, 1'b0};
        return ((PB+1)'(p) > twice) ? PB'((PB+1)'(p) - twice) : '0;
    endfunction

    function automatic logic [M_W-1:0] f_join1(input logic [2*H1-1:0] ll,
                                               input logic [2*H1-1:0] lh,
                                               input logic [2*H1-1:0] hl,
                                               input logic [2*H1-1:0] hh);
        return M_W'(ll) + (M_W'(lh) << H1) + (M_W'(hl) << H1) + (M_W'(hh) << (2 * H1));
    endfunction

    assign {sa, sb, sc} = i_q_sides;

    assign en      = !area_valid || i_out_room;
    assign o_q_pop = i_q_valid && en;
    assign o_push  = area_valid && i_out_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:0], i_q_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a <= PB'(sa);
            r1_b <= PB'(sb);
            r1_c <= PB'(sc);
            r1_p <= PB'(sa) + PB'(sb) + PB'(sc);

            r2_p  <= r1_p;
            r2_fa <= f_factor(r1_p, r1_a);
            r2_fb <= f_factor(r1_p, r1_b);
            r2_fc <= f_factor(r1_p, r1_c);

            r3_p     <= r2_p;
            r3_pp[0] <= H1'(r2_p) * H1'(r2_fa);
            r3_pp[1] <= H1'(r2_p) * H1'(r2_fa >> H1);
            r3_pp[2] <= H1'(r2_p >> H1) * H1'(r2_fa);
            r3_pp[3] <= H1'(r2_p >> H1) * H1'(r2_fa >> H1);
            r3_pp[4] <= H1'(r2_fb) * H1'(r2_fc);
            r3_pp[5] <= H1'(r2_fb) * H1'(r2_fc >> H1);
            r3_pp[6] <= H1'(r2_fb >> H1) * H1'(r2_fc);
            r3_pp[7] <= H1'(r2_fb >> H1) * H1'(r2_fc >> H1);

            r4_p  <= r3_p;
            r4_m1 <= f_join1(r3_pp[0], r3_pp[1], r3_pp[2], r3_pp[3]);
            r4_m2 <= f_join1(r3_pp[4], r3_pp[5], r3_pp[6], r3_pp[7]);

            r5_p     <= r4_p;
            r5_pp[0] <= H2'(r4_m1) * H2'(r4_m2);
            r5_pp[1] <= H2'(r4_m1) * H2'(r4_m2 >> H2);
            r5_pp[2] <= H2'(r4_m1 >> H2) * H2'(r4_m2);
            r5_pp[3] <= H2'(r4_m1 >> H2) * H2'(r4_m2 >> H2);

            r6_p    <= r5_p;
            r6_prod <= PR_W'(r5_pp[0]) + (PR_W'(r5_pp[1]) << H2)
                     + (PR_W'(r5_pp[2]) << H2) + (PR_W'(r5_pp[3]) << (2 * H2));
        end
    end

    tpa_isqrt #(
        .IN_W   (AR_W),
        .SIDE_W (PB)
    ) u_area_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[5]),
        .i_rad   (AR_W'(r6_prod >> SH)),
        .i_side  (r6_p),
        .o_valid (area_valid),
        .o_root  (root),
        .o_side  (perim)
    );

    assign o_word.perimeter = PERIM_W'(perim);
    assign o_word.area      = AREA_W'(root);

endmodule

@@ rtl/core/triangle_perimeter_area_unit.sv @@
// Top level of the triangle perimeter and area unit.
// Usage:
//   Input channel i_in_valid / o_in_ready carries one triangle word: three
//   vertices as signed integer coordinates. Output channel o_out_valid /
//   i_out_ready carries one result word per triangle: perimeter and Heron
//   area, both unsigned with FRAC_BITS fractional bits, in input order.
//   Throughput is one triangle per cycle while the receiver keeps up.
//   The front pipeline holds COORD_BITS + FRAC_BITS + 3 stages ending in the
//   side roots, a four-word queue follows, then six product stages and one
//   stage per area root bit, then a two-word output queue.
//   The bit-serial root pipelines set the latency; each is one compare and
//   subtract per stage.
//   Reset clears all valid bits and both queues; no result is in flight.
//   When the receiver stalls, the output queue fills, the back pipeline
//   holds, the middle queue fills and the front then drops o_in_ready.
//   Each part holds as a whole only when its own last stage has a word that
//   cannot move on.
module triangle_perimeter_area_unit
    import tpa_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int SIDE_W = COORD_BITS + FRAC_BITS + 1;

    logic                f_push;
    logic [3*SIDE_W-1:0] f_sides;
    logic                q_room;
    logic                q_valid;
    logic [3*SIDE_W-1:0] q_sides;
    logic                q_pop;
    logic                b_push;
    t_out_word           b_word;
    logic                out_room;

    tpa_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_word   (i_in_word),
        .o_ready  (o_in_ready),
        .i_q_room (q_room),
        .o_push   (f_push),
        .o_sides  (f_sides)
    );

    tpa_fifo #(
        .W     (3 * SIDE_W),
        .DEPTH (4)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_sides),
        .o_room  (q_room),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_sides)
    );

    tpa_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_sides  (q_sides),
        .o_q_pop    (q_pop),
        .i_out_room (out_room),
        .o_push     (b_push),
        .o_word     (b_word)
    );

    tpa_fifo #(
        .W     ($bits(t_out_word)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_word),
        .o_room  (out_room),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_word)
    );

`ifndef SYNTHESIS
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_room |-> !f_push)
        else $error("front moved into full queue");
    a_mid_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back took word from empty queue");
    a_back_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_push |-> out_room)
        else $error("back pushed into full output queue");
`endif

endmodule

@@ dv/triangle_perimeter_area_unit_test.sv @@
// Testbench for the triangle perimeter and area unit: random and corner triangles checked against a predictor.
module triangle_perimeter_area_unit_test;
    import tpa_pkg::*;

    localparam int CRD_W = 16;
    localparam int FRC_W = 8;
    localparam int LATENCY = 3*CRD_W + 2*FRC_W + 15;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_LEN = 300;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    t_in_word  pending_tris[$];
    t_out_word expected_results[$];
    int        error_count;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off = 0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;
    bit        in_fire = 1'b0;
    bit        stim_done;

    triangle_perimeter_area_unit #(.COORD_BITS(CRD_W), .FRAC_BITS(FRC_W)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt128(logic [127:0] q);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= q) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] side_len(logic signed [15:0] xa, logic signed [15:0] ya,
                                             logic signed [15:0] xb, logic signed [15:0] yb);
        longint dx;
        longint dy;
        logic [127:0] d2;
        dx = longint'(xa) - longint'(xb);
        dy = longint'(ya) - longint'(yb);
        d2 = 128'(dx * dx + dy * dy);
        return isqrt128(d2 << (2 * FRC_W));
    endfunction

    function automatic logic [63:0] heron_term(logic [63:0] p, logic [63:0] s);
        return (p > (s << 1)) ? p - (s << 1) : 64'd0;
    endfunction

    function automatic t_out_word triangle_measures(t_in_word w);
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  c;
        logic [63:0]  p;
        logic [127:0] prod;
        t_out_word    res;
        a = side_len(w.first_x, w.first_y, w.second_x, w.second_y);
        b = side_len(w.third_x, w.third_y, w.second_x, w.second_y);
        c = side_len(w.first_x, w.first_y, w.third_x, w.third_y);
        p = a + b + c;
        prod = 128'(p) * 128'(heron_term(p, a));
        prod = prod * 128'(heron_term(p, b));
        prod = prod * 128'(heron_term(p, c));
        res.perimeter = p[PERIM_W-1:0];
        res.area = AREA_W'(isqrt128(prod >> (2 * FRC_W + 4)));
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 7))
                                                 : 16'h8000 + 16'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic push_tri(logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
                            logic [15:0] y2, logic [15:0] x3, logic [15:0] y3);
        t_in_word w;
        w.first_x = x1; w.first_y = y1; w.second_x = x2;
        w.second_y = y2; w.third_x = x3; w.third_y = y3;
        pending_tris.push_back(w);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_tris.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_word  <= pending_tris.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_off <= hold_off + 1;
            if (hold_off == HOLD_LEN - 1) begin
                hold_done <= 1'b1;
            end
        end else begin
            i_out_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        bit        moved;
        moved = 1'b0;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(triangle_measures(i_in_word));
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", 64'(o_out_word), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_word.perimeter !== want.perimeter)
                        report_mismatch("perimeter", 64'(o_out_word.perimeter), 64'(want.perimeter));
                    if (o_out_word.area !== want.area)
                        report_mismatch("area", 64'(o_out_word.area), 64'(want.area));
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 13;
        recv_idle_pct = 78;
        stim_done = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_tri(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_tri(16'h0000, 16'h0000, 16'h0003, 16'h0000, 16'h0000, 16'h0004);
        push_tri(16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0002, 16'h0002);
        push_tri(16'h0000, 16'h0000, 16'h0005, 16'h0000, 16'h0005, 16'h0000);
        push_tri(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        push_tri(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        push_tri(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        push_tri(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        push_tri(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0001);
        push_tri(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
        push_tri(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0064, 16'h0001);
        push_tri(16'h8000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);
        push_tri(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h1234, 16'hedcb);

        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < 630; n++) begin
                int m;
                m = $urandom_range(0, 9);
                m = (m < 6) ? 0 : (m < 9) ? 1 : 2;
                push_tri(rand_coord(m), rand_coord(m), rand_coord(m),
                         rand_coord(m), rand_coord(m), rand_coord(m));
                if (ph == 0 && n == 200) hold_req = 1'b1;
            end
            while (pending_tris.size() > 0) @(posedge i_clk);
            if (ph == 0) begin
                send_idle_pct = 78;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        @(posedge i_clk);
        while (i_in_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/tpa_pkg.sv
rtl/core/tpa_isqrt.sv
rtl/core/tpa_fifo.sv
rtl/core/tpa_front.sv
rtl/core/tpa_back.sv
rtl/core/triangle_perimeter_area_unit.sv
dv/triangle_perimeter_area_unit_test.sv
